@@ design/trvcf_pkg.sv @@
// ----------------------------------------------------------------------------
// trvcf_pkg
// Shared constants, types and helpers of the texture rectangle vertical
// clip filter.
// ----------------------------------------------------------------------------
package trvcf_pkg;

    // View band height in lines (one half of the split screen)
    localparam int BAND_LINES = 480;
    localparam int HALF_BAND  = BAND_LINES / 2;

    // Line field inside the command words
    localparam int LINE_FLD_W = 12;
    // Signed width that holds a shifted line field and both band edges
    localparam int LINE_W = $clog2((1 << LINE_FLD_W) + 2 * BAND_LINES) + 1;
    // Clipped line count never exceeds the band height
    localparam int CLIP_W = $clog2(BAND_LINES + 1);
    // Texture T and dtdy are signed 16-bit fields
    localparam int TEX_W  = 16;
    localparam int PROD_W = CLIP_W + 1 + TEX_W;
    // T advance is divided by 128
    localparam int TDIV_SH = 7;

    // Opcodes and scissor rewrite bases
    localparam logic [7:0]  OP_TEXRECT  = 8'hE4;
    localparam logic [7:0]  OP_SCISSOR  = 8'hED;
    localparam logic [31:0] SCISSOR_HI  = 32'hED00_0000;
    localparam logic [31:0] SCISSOR_LO  = 32'h006A_0000;

    // Result queue
    localparam int QDEPTH = 4;
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // Work kinds carried by the staged item
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_PLAIN = 2'd0;  // one doubleword, scissor rewritten
    localparam t_kind KIND_FLUSH = 2'd1;  // list ended after rectangle head
    localparam t_kind KIND_RECT  = 2'd2;  // third rectangle doubleword

    // Rectangle buffering phases
    typedef logic [1:0] t_phase;
    localparam t_phase PH_IDLE = 2'd0;
    localparam t_phase PH_HEAD = 2'd1;
    localparam t_phase PH_TEX  = 2'd2;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] hi;
        logic [31:0] lo;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [31:0] head_hi;
        logic [31:0] head_lo;
        logic [31:0] tex_hi;
        logic [31:0] tex_lo;
    } t_rect;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
        logic        has_word;
        logic        eol;
    } t_res;

    // Top line of the view band
    function automatic logic signed [LINE_W-1:0] band_top(input logic view);
        band_top = view ? LINE_W'(BAND_LINES) : '0;
    endfunction

    // Pass a doubleword, rewriting a scissor command to the band
    function automatic t_res plain_word(input logic [31:0] hi, input logic [31:0] lo,
                                        input logic view);
        logic [LINE_W-1:0] top;
        logic [LINE_W-1:0] bot;
        t_res              r;
        top        = band_top(view);
        bot        = top + LINE_W'(BAND_LINES);
        r.hi       = hi;
        r.lo       = lo;
        r.has_word = 1'b1;
        r.eol      = 1'b0;
        if (hi[31:24] == OP_SCISSOR) begin
            r.hi = SCISSOR_HI | {{(32-LINE_W){1'b0}}, top};
            r.lo = SCISSOR_LO | {{(32-LINE_W){1'b0}}, bot};
        end
        plain_word = r;
    endfunction

endpackage

@@ design/trvcf_front.sv @@
// ----------------------------------------------------------------------------
// trvcf_front
// Input register, rectangle buffering and phase tracking.
// ----------------------------------------------------------------------------
module trvcf_front
    import trvcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_hi,
    input  logic [31:0] i_lo,
    input  logic        i_last,
    input  logic        i_adv,
    output t_item       o_item,
    output t_rect       o_rect
);

    t_phase r_phase, n_phase;
    logic   r_valid, n_valid;
    t_kind  r_kind, n_kind;
    logic [31:0] r_hi, r_lo;
    logic        r_last;
    t_rect       r_rect;
    logic        accept, wr_head, wr_tex;

    assign o_ready = !r_valid || i_adv;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_phase = r_phase;
        n_kind  = KIND_PLAIN;
        n_valid = r_valid && !i_adv;
        wr_head = 1'b0;
        wr_tex  = 1'b0;
        if (accept) begin
            n_valid = 1'b1;
            n_phase = PH_IDLE;
            case (r_phase)
                PH_HEAD: begin
                    if (i_last) begin
                        n_kind = KIND_FLUSH;
                    end else begin
                        wr_tex  = 1'b1;
                        n_phase = PH_TEX;
                        n_valid = 1'b0;
                    end
                end
                PH_TEX: begin
                    n_kind = KIND_RECT;
                end
                default: begin
                    if (i_hi[31:24] == OP_TEXRECT && !i_last) begin
                        wr_head = 1'b1;
                        n_phase = PH_HEAD;
                        n_valid = 1'b0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= n_kind;
            r_hi   <= i_hi;
            r_lo   <= i_lo;
            r_last <= i_last;
        end
        if (wr_head) begin
            r_rect.head_hi <= i_hi;
            r_rect.head_lo <= i_lo;
        end
        if (wr_tex) begin
            r_rect.tex_hi <= i_hi;
            r_rect.tex_lo <= i_lo;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.kind  = r_kind;
    assign o_item.hi    = r_hi;
    assign o_item.lo    = r_lo;
    assign o_item.last  = r_last;
    assign o_rect       = r_rect;

endmodule

@@ design/trvcf_clip.sv @@
// ----------------------------------------------------------------------------
// trvcf_clip
// Band clip of a texture rectangle and result formation for a staged item.
// ----------------------------------------------------------------------------
module trvcf_clip
    import trvcf_pkg::*;
(
    input  t_item      i_item,
    input  t_rect      i_rect,
    input  logic       i_view,
    output logic [1:0] o_n,
    output t_res       o_res [0:2]
);

    logic signed [LINE_W-1:0] top, bot, shift, old_top, old_bot, y0, y1, clipped_s;
    logic [CLIP_W-1:0]        clipped;
    logic signed [PROD_W-1:0] prod, adj, quo;
    logic [TEX_W-1:0]         t_new;
    logic                     keep;
    logic [1:0]               n_pre, n_fin;
    t_res                     res [0:2];

    always_comb begin
        top       = band_top(i_view);
        bot       = top + LINE_W'(BAND_LINES);
        shift     = i_view ? LINE_W'(HALF_BAND) : -LINE_W'(HALF_BAND);
        old_top   = $signed({{(LINE_W-LINE_FLD_W){1'b0}}, i_rect.head_lo[LINE_FLD_W-1:0]})
                    + shift;
        old_bot   = $signed({{(LINE_W-LINE_FLD_W){1'b0}}, i_rect.head_hi[LINE_FLD_W-1:0]})
                    + shift;
        y0        = (old_top > top) ? old_top : top;
        y1        = (old_bot < bot) ? old_bot : bot;
        keep      = y0 < y1;
        clipped_s = y0 - old_top;
        clipped   = clipped_s[CLIP_W-1:0];
        // Advance T by clipped * dtdy / 128, rounding toward zero
        prod  = $signed({1'b0, clipped}) * $signed(i_item.lo[TEX_W-1:0]);
        adj   = prod + (prod[PROD_W-1] ? PROD_W'((1 << TDIV_SH) - 1) : '0);
        quo   = adj >>> TDIV_SH;
        t_new = i_rect.tex_lo[TEX_W-1:0] + quo[TEX_W-1:0];
    end

    always_comb begin
        res[0] = plain_word(i_item.hi, i_item.lo, i_view);
        res[1] = res[0];
        res[2] = res[0];
        n_pre  = 2'd1;
        case (i_item.kind)
            KIND_FLUSH: begin
                res[0] = '{hi: i_rect.head_hi, lo: i_rect.head_lo, has_word: 1'b1,
                           eol: 1'b0};
                res[1] = plain_word(i_item.hi, i_item.lo, i_view);
                n_pre  = 2'd2;
            end
            KIND_RECT: begin
                res[0] = '{hi: {i_rect.head_hi[31:LINE_FLD_W], y1[LINE_FLD_W-1:0]},
                           lo: {i_rect.head_lo[31:LINE_FLD_W], y0[LINE_FLD_W-1:0]},
                           has_word: 1'b1, eol: 1'b0};
                res[1] = '{hi: i_rect.tex_hi, lo: {i_rect.tex_lo[31:TEX_W], t_new},
                           has_word: 1'b1, eol: 1'b0};
                res[2] = '{hi: i_item.hi, lo: i_item.lo, has_word: 1'b1, eol: 1'b0};
                n_pre  = keep ? 2'd3 : 2'd0;
            end
            default: begin
                n_pre = 2'd1;
            end
        endcase

        // A dropped rectangle that ends the list leaves a bare end marker
        n_fin = n_pre;
        if (i_item.last && n_pre == 2'd0) begin
            res[0] = '{hi: '0, lo: '0, has_word: 1'b0, eol: 1'b0};
            n_fin  = 2'd1;
        end
        for (int k = 0; k < 3; k++) begin
            o_res[k]     = res[k];
            o_res[k].eol = i_item.last && (2'(k) == n_fin - 2'd1);
        end
        o_n = n_fin;
    end

endmodule

@@ design/trvcf_outq.sv @@
// ----------------------------------------------------------------------------
// trvcf_outq
// Result queue: takes up to three results a cycle, delivers one while the receiver is ready.
// ----------------------------------------------------------------------------
module trvcf_outq
    import trvcf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [1:0]       i_push_n,
    input  t_res             i_push [0:2],
    output logic [CNT_W-1:0] o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output t_res             o_res
);

    logic [CNT_W-1:0] r_count, n_count, base, off;
    t_res             r_ent [0:QDEPTH-1];
    t_res             n_ent [0:QDEPTH-1];
    logic             pop;

    assign o_valid = r_count != '0;
    assign o_res   = r_ent[0];
    assign o_room  = CNT_W'(QDEPTH) - r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        base    = r_count - CNT_W'(pop);
        n_count = base + CNT_W'(i_push_n);
        for (int i = 0; i < QDEPTH; i++) begin
            // Shift down on pop, then drop new results in behind the survivors
            if (pop && i < QDEPTH - 1) begin
                n_ent[i] = r_ent[i+1];
            end else begin
                n_ent[i] = r_ent[i];
            end
            off = CNT_W'(i) - base;
            if (CNT_W'(i) >= base && CNT_W'(i) < n_count) begin
                n_ent[i] = i_push[off[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

endmodule

@@ design/texture_rect_vertical_clip_filter.sv @@
// ----------------------------------------------------------------------------
// texture_rect_vertical_clip_filter
// Display list filter: clips texture rectangles to one split-screen view band,
// rewrites scissor commands to the band and passes other doublewords.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------
//  in      | sink      | i_in_valid / o_in_ready    | i_cmd_hi, i_cmd_lo,
//          |           |                            | i_is_last
//  out     | source    | o_out_valid / i_out_ready  | o_out_hi, o_out_lo,
//          |           |                            | o_has_word, o_end_of_list
//  cfg     | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_view_index
//
//  One doubleword is taken every cycle while the input is not stalled. An
//  accepted doubleword is held in the input register, where the clip (one
//  10x16 multiply, a shift and an add) forms its zero to three results; they
//  land in a four-entry result queue and the first shows on the output the
//  cycle after if the queue was empty. The input stalls only when the staged
//  results do not fit in the queue, so a downstream stall backs up through the queue first.
//  Reset is synchronous: it clears the rectangle phase, the view select, the
//  staged valid flag and the queue count. Rectangle buffers hold garbage until
//  written.
//
module texture_rect_vertical_clip_filter
    import trvcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_cmd_hi,
    input  logic [31:0] i_cmd_lo,
    input  logic        i_is_last,
    // command output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_hi,
    output logic [31:0] o_out_lo,
    output logic        o_has_word,
    output logic        o_end_of_list,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_view_index
);

    logic             r_view;
    t_item            s_item;
    t_rect            s_rect;
    logic [1:0]       s_n;
    t_res             s_res [0:2];
    logic [CNT_W-1:0] s_room;
    logic             s_adv;
    logic [1:0]       s_push_n;
    t_res             s_out;

    // View select register; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view <= 1'b0;
        end else if (i_cfg_valid) begin
            r_view <= i_cfg_view_index;
        end
    end

    trvcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_hi    (i_cmd_hi),
        .i_lo    (i_cmd_lo),
        .i_last  (i_is_last),
        .i_adv   (s_adv),
        .o_item  (s_item),
        .o_rect  (s_rect)
    );

    trvcf_clip u_clip (
        .i_item (s_item),
        .i_rect (s_rect),
        .i_view (r_view),
        .o_n    (s_n),
        .o_res  (s_res)
    );

    // Advance the staged item once all of its results fit in the queue
    assign s_adv    = s_item.valid && (CNT_W'(s_n) <= s_room);
    assign s_push_n = s_adv ? s_n : 2'd0;

    trvcf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (s_push_n),
        .i_push   (s_res),
        .o_room   (s_room),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_res    (s_out)
    );

    assign o_out_hi      = s_out.hi;
    assign o_out_lo      = s_out.lo;
    assign o_has_word    = s_out.has_word;
    assign o_end_of_list = s_out.eol;

    // A staged item that cannot advance must block the input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_item.valid && !s_adv |-> !o_in_ready)
        else $error("input ready while staged item is stuck");

    // A bare end marker only closes a list and carries zero words
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_word |-> o_end_of_list && o_out_hi == '0 && o_out_lo == '0)
        else $error("malformed bare end marker");

    // The last doubleword of a list always yields at least one result
    a_last_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_adv && s_item.last |-> s_push_n != 2'd0)
        else $error("end of list produced no result");

endmodule

@@ tb/trvcf_clip_checker.sv @@
// ----------------------------------------------------------------------------
// trvcf_clip_checker
// Watches the command, result and view-select channels of the texture
// rectangle vertical clip filter. It predicts the rewritten list, compares
// each result transaction and hands the failure and backlog counts up.
// ----------------------------------------------------------------------------
module trvcf_clip_checker
    import trvcf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_cmd_hi,
    input  logic [31:0] i_cmd_lo,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_hi,
    input  logic [31:0] i_out_lo,
    input  logic        i_has_word,
    input  logic        i_end_of_list,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_view_index,
    output int          o_failures,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int T_STEP_DIV = 128;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
        logic        has_word;
        logic        eol;
    } t_dw_out;

    t_dw_out     emitted_q[$];
    logic        view;
    t_phase      phase;
    logic [31:0] head_hi, head_lo, tex_hi, tex_lo;
    int          failures = 0;

    assign o_failures = failures;

    function automatic t_dw_out word_out(input logic [31:0] hi, input logic [31:0] lo);
        return '{hi, lo, 1'b1, 1'b0};
    endfunction

    // Rewrite a scissor to the current band, pass anything else
    function automatic t_dw_out band_plain(input logic [31:0] hi, input logic [31:0] lo);
        int top;
        top = view ? BAND_LINES : 0;
        if (hi[31:24] == OP_SCISSOR) begin
            hi = SCISSOR_HI | 32'(top);
            lo = SCISSOR_LO | 32'(top + BAND_LINES);
        end
        return word_out(hi, lo);
    endfunction

    task automatic clip_rect(input logic [31:0] third_hi, input logic [31:0] third_lo,
                             ref t_dw_out res[$]);
        int          top, bot, shift, old_top, old_bot, y0, y1, t_new;
        logic [31:0] t_lo;
        top     = view ? BAND_LINES : 0;
        bot     = top + BAND_LINES;
        shift   = view ? HALF_BAND : -HALF_BAND;
        old_top = int'(head_lo[11:0]) + shift;
        old_bot = int'(head_hi[11:0]) + shift;
        y0      = (old_top > top) ? old_top : top;
        y1      = (old_bot < bot) ? old_bot : bot;
        // nothing left inside the band: drop all three doublewords
        if (y0 < y1) begin
            t_new = int'($signed(tex_lo[15:0]))
                  + ((y0 - old_top) * int'($signed(third_lo[15:0]))) / T_STEP_DIV;
            t_lo  = {tex_lo[31:16], t_new[15:0]};
            res.push_back(word_out({head_hi[31:12], y1[11:0]}, {head_lo[31:12], y0[11:0]}));
            res.push_back(word_out(tex_hi, t_lo));
            res.push_back(word_out(third_hi, third_lo));
        end
    endtask

    task automatic predict_doubleword(input logic [31:0] hi, input logic [31:0] lo,
                                      input logic last);
        t_dw_out res[$];
        case (phase)
            PH_HEAD: begin
                if (last) begin
                    res.push_back(word_out(head_hi, head_lo));
                    res.push_back(band_plain(hi, lo));
                    phase = PH_IDLE;
                end else begin
                    tex_hi = hi;
                    tex_lo = lo;
                    phase  = PH_TEX;
                end
            end
            PH_TEX: begin
                clip_rect(hi, lo, res);
                phase = PH_IDLE;
            end
            default: begin
                phase = PH_IDLE;
                if (hi[31:24] == OP_TEXRECT && !last) begin
                    head_hi = hi;
                    head_lo = lo;
                    phase   = PH_HEAD;
                end else begin
                    res.push_back(band_plain(hi, lo));
                end
            end
        endcase
        if (last) begin
            // bare end marker when the closing doubleword emits nothing
            if (res.size() == 0)
                res.push_back('0);
            res[res.size() - 1].eol = 1'b1;
        end
        foreach (res[k])
            emitted_q.push_back(res[k]);
    endtask

    task automatic note_failure(input string what, input t_dw_out want, input t_dw_out got);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s: exp hi=%h lo=%h word=%b eol=%b, got hi=%h lo=%h word=%b eol=%b",
                     $time, what, want.hi, want.lo, want.has_word, want.eol,
                     got.hi, got.lo, got.has_word, got.eol);
    endtask

    always @(posedge i_clk) begin
        t_dw_out got;
        t_dw_out want;
        if (!i_rst_n) begin
            view  = 1'b0;
            phase = PH_IDLE;
            emitted_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_hi, i_out_lo, i_has_word, i_end_of_list};
                if (emitted_q.size() == 0) begin
                    note_failure("unexpected result", '0, got);
                end else begin
                    want = emitted_q.pop_front();
                    if (got.hi !== want.hi || got.lo !== want.lo ||
                        got.has_word !== want.has_word || got.eol !== want.eol)
                        note_failure("result mismatch", want, got);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                view = i_cfg_view_index;
            if (i_in_valid && i_in_ready)
                predict_doubleword(i_cmd_hi, i_cmd_lo, i_is_last);
        end
        o_pending = emitted_q.size();
    end

endmodule

@@ tb/texture_rect_vertical_clip_filter_test.sv @@
// ----------------------------------------------------------------------------
// texture_rect_vertical_clip_filter_test
// Drives command lists through the clip filter under both view bands, with
// bursty input and a stalling receiver; a side checker predicts every result.
// ----------------------------------------------------------------------------
module texture_rect_vertical_clip_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import trvcf_pkg::*;

    // receiver stall patterns
    localparam int RX_OPEN    = 0;
    localparam int RX_CHOPPY  = 1;
    localparam int RX_CLOGGED = 2;

    // cycles to let a staged doubleword work through after the backlog empties
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 22;
    localparam int RAND_PHASES   = 6;

    typedef struct packed {
        logic [31:0] hi;
        logic [31:0] lo;
    } t_dw;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] cmd_hi;
    logic [31:0] cmd_lo;
    logic        is_last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] out_hi;
    logic [31:0] out_lo;
    logic        has_word;
    logic        end_of_list;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_view;
    int          failures;
    int          pending;
    int          burst_left = 0;
    int          items_sent = 0;

    texture_rect_vertical_clip_filter i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_cmd_hi         (cmd_hi),
        .i_cmd_lo         (cmd_lo),
        .i_is_last        (is_last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_out_hi         (out_hi),
        .o_out_lo         (out_lo),
        .o_has_word       (has_word),
        .o_end_of_list    (end_of_list),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_view_index (cfg_view)
    );

    trvcf_clip_checker i_clip_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_cmd_hi         (cmd_hi),
        .i_cmd_lo         (cmd_lo),
        .i_is_last        (is_last),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_hi         (out_hi),
        .i_out_lo         (out_lo),
        .i_has_word       (has_word),
        .i_end_of_list    (end_of_list),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_view_index (cfg_view),
        .o_failures       (failures),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #200000;
        $display("texture_rect_vertical_clip_filter_test: done, errors");
        $finish;
    end

    // Receiver: hold one stall pattern for a random stretch, then switch
    initial begin
        int mode;
        int span;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(RX_OPEN, RX_CLOGGED);
            span = $urandom_range(16, 80);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_CHOPPY: out_ready <= ($urandom_range(0, 1) == 1);
                    default:   out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one doubleword; enter and leave at a falling edge. Open a gap
    // only between bursts, so valid is never dropped and raised in one step.
    task automatic send_dw(input logic [31:0] hi, input logic [31:0] lo, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_valid <= 1'b1;
        cmd_hi   <= hi;
        cmd_lo   <= lo;
        is_last  <= last;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every expected result, then let the
    // pipeline settle in case the final doubleword produced nothing.
    task automatic drain();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_view(input logic v);
        cfg_valid <= 1'b1;
        cfg_view  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_dw rect_head(input int bot, input int top);
        return '{{OP_TEXRECT, 12'($urandom), 12'(bot)}, {20'($urandom), 12'(top)}};
    endfunction

    // 16-bit signed field, biased toward its extremes
    function automatic logic [15:0] tex_half();
        case ($urandom_range(0, 5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Lines mostly near the band so that every clip case shows up
    function automatic t_dw random_rect_head();
        int top;
        int bot;
        top = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(150, 800);
        if ($urandom_range(0, 3) == 0)
            bot = $urandom_range(0, 4095);
        else
            bot = top + $urandom_range(0, 560) - 40;
        if (bot < 0)
            bot = 0;
        if (bot > 4095)
            bot = 4095;
        return rect_head(bot, top);
    endfunction

    function automatic t_dw random_tex_word();
        return '{$urandom, {16'($urandom), tex_half()}};
    endfunction

    // One list of well-formed rectangles, scissors and plain words, with
    // some broken rectangles; the final doubleword carries the end flag.
    task automatic send_random_list();
        t_dw words[$];
        int  len;
        int  pick;
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
        while (words.size() < len) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                words.push_back(random_rect_head());
                words.push_back(random_tex_word());
                words.push_back(random_tex_word());
            end else if (pick <= 6) begin
                words.push_back('{{OP_SCISSOR, 24'($urandom)}, $urandom});
            end else if (pick == 7) begin
                // truncated rectangle: no closing doubleword
                words.push_back(random_rect_head());
                if ($urandom_range(0, 1) == 1)
                    words.push_back(random_tex_word());
            end else begin
                words.push_back('{$urandom, $urandom});
            end
        end
        foreach (words[k])
            send_dw(words[k].hi, words[k].lo, k == words.size() - 1);
        items_sent += words.size();
    endtask

    initial begin
        t_dw d;
        int  target;
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        cmd_hi    = '0;
        cmd_lo    = '0;
        is_last   = 1'b0;
        cfg_valid = 1'b0;
        cfg_view  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---- directed: upper band ----
        write_view(1'b0);
        send_dw(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_dw(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_dw({OP_SCISSOR, 24'h12_3456}, 32'h89AB_CDEF, 1'b0);
        // rectangle fully inside the band
        d = rect_head(600, 300);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, {16'hBEEF, 16'h1234}, 1'b0);
        send_dw($urandom, {16'h0000, 16'h0400}, 1'b0);
        // top clipped, most negative dtdy: T wraps
        d = rect_head(500, 100);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, {16'h5555, 16'h7FFF}, 1'b0);
        send_dw($urandom, {16'hAAAA, 16'h8000}, 1'b0);
        // clipped away entirely
        d = rect_head(900, 800);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, $urandom, 1'b0);
        send_dw($urandom, $urandom, 1'b0);
        // full-scale line fields, largest dtdy
        d = rect_head(12'hFFF, 0);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, {16'h0000, 16'h8000}, 1'b0);
        send_dw($urandom, {16'hFFFF, 16'h7FFF}, 1'b0);
        // one clipped line at dtdy -1: advance truncates to zero; list ends
        d = rect_head(400, 239);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, $urandom, 1'b0);
        send_dw($urandom, {16'h0000, 16'hFFFF}, 1'b1);
        // rectangle opcode on the final doubleword
        d = rect_head(400, 300);
        send_dw(d.hi, d.lo, 1'b1);
        // list ends right after the head: flush it, rewrite the scissor
        d = rect_head(400, 300);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw({OP_SCISSOR, 24'h00_0000}, 32'h0000_0000, 1'b1);
        // dropped rectangle closes the list: bare end marker
        d = rect_head(100, 50);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, $urandom, 1'b0);
        send_dw($urandom, $urandom, 1'b1);

        // ---- directed: lower band ----
        drain();
        write_view(1'b1);
        d = rect_head(900, 500);
        send_dw(d.hi, d.lo, 1'b0);
        send_dw($urandom, $urandom, 1'b0);
        send_dw($urandom, {16'h1111, 16'h0100}, 1'b0);
        send_dw({OP_SCISSOR, 24'hFF_FFFF}, 32'hFFFF_FFFF, 1'b1);

        // ---- random phases, view changed only while drained ----
        items_sent = 0;
        target     = 0;
        for (int p = 0; p < RAND_PHASES; p++) begin
            drain();
            write_view((p < 2) ? p[0] : 1'($urandom_range(0, 1)));
            target += PHASE_ITEMS;
            while (items_sent < target)
                send_random_list();
        end

        drain();
        if (failures == 0 && pending == 0)
            $display("texture_rect_vertical_clip_filter_test: done, clean");
        else
            $display("texture_rect_vertical_clip_filter_test: done, errors");
        $finish;
    end

endmodule
